/* hdl/tga_pkg.sv */
package tga_pkg;

  // Packet header split point: below this a raw packet, else a run
  localparam int unsigned MAX_PACKET = 128;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RLE_MODE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  // Fault codes
  localparam logic [1:0] FAULT_OK        = 2'd0;
  localparam logic [1:0] FAULT_CLIPPED   = 2'd1;
  localparam logic [1:0] FAULT_TRUNCATED = 2'd2;

  // One result word as held in the output queue
  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic [1:0]  fault;
  } pixel_word_t;

endpackage

/* hdl/tga_byte_if.sv */
interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

/* hdl/tga_pixel_if.sv */
interface tga_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        image_done;
  logic [1:0]  fault;

  modport source (output valid, output pixel_value, output repeat_count,
                  output image_done, output fault, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count,
                  input image_done, input fault, output ready);
endinterface

/* hdl/tga_cfg_if.sv */
interface tga_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/tga_rle_pixel_decoder.sv */
// TGA run-length pixel decoder.
//
// data_in takes one image data byte per word (after the file header), with
// stream_end marking the last byte the source holds. pixel_out delivers one
// word per assembled pixel: the pixel, a repeat count for a downstream
// expander, an image-done flag and a fault code. cfg writes the four frame
// registers (rle mode, bytes per pixel, width, height); any write restarts
// the frame. cfg is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce.
// Each byte is decoded in the cycle it is accepted and its result, if any,
// lands in a two-word output queue: one byte per cycle while the queue has
// room; a result reaches pixel_out only from its registered queue slot.
// data_in stays ready while the queue holds fewer than two words, so a single
// stalled result does not hold off the next byte; with both words waiting,
// data_in drops ready until pixel_out takes one.
//
// Reset (rst, synchronous) loads rle mode, 3 bytes per pixel and a 1x1
// image, empties the queue and waits for a packet header. Once the image is
// complete or the stream has ended, further bytes are taken and dropped.
module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  tga_cfg_if.sink     cfg,
  tga_byte_if.sink    data_in,
  tga_pixel_if.source pixel_out
);
  import tga_pkg::*;

  // Frame registers
  logic        rle_mode;
  logic [2:0]  pixel_bytes;
  logic [15:0] image_width;
  logic [15:0] image_height;

  // Decode state
  logic        expect_header, expect_header_next;
  logic        run_packet, run_packet_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] pixel_accumulator, pixel_accumulator_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic        finished, finished_next;

  // Output queue
  pixel_word_t slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  cnt;

  logic        cfg_write, in_accept, push, pop;
  logic        emit;
  pixel_word_t res;

  // Restart values from the registers as they stand after this write
  logic [15:0] new_width, new_height;
  logic [31:0] new_pixels;

  assign cfg.ready      = 1'b1;
  assign cfg_write      = cfg.valid && cfg.ready;
  assign data_in.ready  = (cnt != 2'd2);
  assign in_accept      = data_in.valid && data_in.ready;
  assign push           = in_accept && emit;
  assign pop            = pixel_out.valid && pixel_out.ready;

  assign new_width  = (cfg.index == REG_IMAGE_WIDTH)  ? cfg.data : image_width;
  assign new_height = (cfg.index == REG_IMAGE_HEIGHT) ? cfg.data : image_height;
  assign new_pixels = 32'(new_width) * 32'(new_height);

  // Per-byte decode
  always_comb begin
    logic [1:0]  last_index;
    logic [31:0] acc_new;
    logic [7:0]  count;
    logic        clip, done;
    logic [1:0]  fault;

    expect_header_next     = expect_header;
    run_packet_next        = run_packet;
    packet_left_next       = packet_left;
    byte_index_next        = byte_index;
    pixel_accumulator_next = pixel_accumulator;
    pixels_left_next       = pixels_left;
    finished_next          = finished;
    emit                   = 1'b0;
    res                    = '0;
    count                  = 8'd1;
    clip                   = 1'b0;
    done                   = 1'b0;
    fault                  = FAULT_OK;

    // Bytes per pixel minus one, out-of-range sizes clamped
    case (pixel_bytes)
      3'd0, 3'd1: last_index = 2'd0;
      3'd2:       last_index = 2'd1;
      3'd3:       last_index = 2'd2;
      default:    last_index = 2'd3;
    endcase

    acc_new = pixel_accumulator | ({24'd0, data_in.data_byte} << {byte_index, 3'b000});

    if (finished) begin
      // drop everything until restart
    end else if (rle_mode && expect_header) begin
      // packet header
      if (data_in.data_byte < 8'(MAX_PACKET)) begin
        run_packet_next  = 1'b0;
        packet_left_next = data_in.data_byte + 8'd1;
      end else begin
        run_packet_next  = 1'b1;
        packet_left_next = data_in.data_byte - 8'(MAX_PACKET - 1);
      end
      expect_header_next     = 1'b0;
      byte_index_next        = 2'd0;
      pixel_accumulator_next = '0;
      if (data_in.stream_end) begin
        finished_next = 1'b1;
        emit          = 1'b1;
        res.fault     = FAULT_TRUNCATED;
      end
    end else if (byte_index != last_index) begin
      // partial pixel
      pixel_accumulator_next = acc_new;
      byte_index_next        = byte_index + 2'd1;
      if (data_in.stream_end) begin
        finished_next = 1'b1;
        emit          = 1'b1;
        res.fault     = FAULT_TRUNCATED;
      end
    end else begin
      // pixel complete
      byte_index_next        = 2'd0;
      pixel_accumulator_next = '0;
      if (rle_mode && run_packet) begin
        count            = packet_left;
        packet_left_next = '0;
      end else if (rle_mode && packet_left != 8'd0) begin
        packet_left_next = packet_left - 8'd1;
      end
      if (rle_mode && packet_left_next == 8'd0) begin
        expect_header_next = 1'b1;
      end

      clip = {24'd0, count} > pixels_left;
      done = {24'd0, count} >= pixels_left;
      if (clip) begin
        count = pixels_left[7:0];
      end
      pixels_left_next = pixels_left - {24'd0, count};

      if (clip || (done && rle_mode && packet_left_next != 8'd0)) begin
        fault = FAULT_CLIPPED;
      end
      if (!done && data_in.stream_end) begin
        fault = FAULT_TRUNCATED;
      end
      if (done || data_in.stream_end) begin
        finished_next = 1'b1;
      end

      emit             = 1'b1;
      res.pixel_value  = acc_new;
      res.repeat_count = count;
      res.image_done   = done;
      res.fault        = fault;
    end
  end

  // Frame registers and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode          <= 1'b1;
      pixel_bytes       <= 3'd3;
      image_width       <= 16'd1;
      image_height      <= 16'd1;
      expect_header     <= 1'b1;
      run_packet        <= 1'b0;
      packet_left       <= '0;
      byte_index        <= '0;
      pixel_accumulator <= '0;
      pixels_left       <= 32'd1;
      finished          <= 1'b0;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_RLE_MODE:     rle_mode     <= cfg.data[0];
        REG_PIXEL_BYTES:  pixel_bytes  <= cfg.data[2:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
      expect_header     <= 1'b1;
      run_packet        <= 1'b0;
      packet_left       <= '0;
      byte_index        <= '0;
      pixel_accumulator <= '0;
      pixels_left       <= new_pixels;
      finished          <= (new_pixels == 32'd0);
    end else if (in_accept) begin
      expect_header     <= expect_header_next;
      run_packet        <= run_packet_next;
      packet_left       <= packet_left_next;
      byte_index        <= byte_index_next;
      pixel_accumulator <= pixel_accumulator_next;
      pixels_left       <= pixels_left_next;
      finished          <= finished_next;
    end
  end

  // Output queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= res;
    end
  end

  // Output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign pixel_out.valid        = (cnt != 2'd0);
  assign pixel_out.pixel_value  = slots[rd_ptr].pixel_value;
  assign pixel_out.repeat_count = slots[rd_ptr].repeat_count;
  assign pixel_out.image_done   = slots[rd_ptr].image_done;
  assign pixel_out.fault        = slots[rd_ptr].fault;

  // A completing word stops the frame
  a_done_finishes: assert property (@(posedge clk) disable iff (rst)
    (push && res.image_done) |=> finished)
    else $error("image done word did not finish the frame");

  // No word is made once the frame is finished
  a_quiet_after_finish: assert property (@(posedge clk) disable iff (rst)
    finished |-> !emit)
    else $error("word produced after frame finished");

  // A word with no pixel is only an early stream end
  a_empty_is_truncated: assert property (@(posedge clk) disable iff (rst)
    (push && res.repeat_count == 8'd0) |-> (res.fault == FAULT_TRUNCATED))
    else $error("empty word without truncation fault");

  // Repeats never run past the image
  a_count_in_image: assert property (@(posedge clk) disable iff (rst)
    push |-> ({24'd0, res.repeat_count} <= pixels_left))
    else $error("repeat count exceeds pixels left");

endmodule

/* tb/tga_rle_pixel_decoder_tb.sv */
module tga_rle_pixel_decoder_tb;
  import tga_pkg::*;

  localparam int TIMEOUT_UNITS = 5_000_000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int PHASES        = 4;
  localparam int PHASE_BYTES   = 350;
  localparam int SRC_IDLE_PCT [PHASES]  = '{0, 66, 0, 23};
  localparam int SINK_STALL_PCT [PHASES] = '{0, 0, 66, 23};

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  // One step of the directed sequence: a register write or a data byte
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [15:0] val;
    logic [7:0]  b;
    logic        last;
    logic        typed;
    pixel_word_t want;
  } plan_row_t;

  localparam pixel_word_t NO_WORD = '0;
  localparam int PLAN_ROWS = 35;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset frame: 1x1, 3 bytes, raw header then one pixel, then a stray byte
    '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h11, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h22, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h33, 1'b0, 1'b1, '{32'h0033_2211, 8'd1, 1'b1, FAULT_OK}},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    // 2x1, 4 bytes: longest run clipped to the image
    '{ROW_REG, REG_PIXEL_BYTES, 16'd4, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, REG_IMAGE_WIDTH, 16'd2, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, 1'b1, '{32'hFFFF_FFFF, 8'd2, 1'b1, FAULT_CLIPPED}},
    // 3x1, 1 byte: longest raw packet cut off at the image end
    '{ROW_REG, REG_PIXEL_BYTES, 16'd1, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, REG_IMAGE_WIDTH, 16'd3, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h7F, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h00, 1'b0, 1'b1, '{32'h0000_0000, 8'd1, 1'b0, FAULT_OK}},
    '{ROW_BYTE, '0, '0, 8'h80, 1'b0, 1'b1, '{32'h0000_0080, 8'd1, 1'b0, FAULT_OK}},
    '{ROW_BYTE, '0, '0, 8'hAA, 1'b0, 1'b1, '{32'h0000_00AA, 8'd1, 1'b1, FAULT_CLIPPED}},
    // plain mode, largest image, stream ends inside a pixel
    '{ROW_REG, REG_RLE_MODE, 16'd0, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, REG_PIXEL_BYTES, 16'd2, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, REG_IMAGE_WIDTH, 16'hFFFF, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, REG_IMAGE_HEIGHT, 16'hFFFF, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h01, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h02, 1'b0, 1'b1, '{32'h0000_0201, 8'd1, 1'b0, FAULT_OK}},
    '{ROW_BYTE, '0, '0, 8'h03, 1'b1, 1'b1, '{32'h0, 8'd0, 1'b0, FAULT_TRUNCATED}},
    // zero pixel size taken as one; empty image drops every byte
    '{ROW_REG, REG_RLE_MODE, 16'd1, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, REG_PIXEL_BYTES, 16'd0, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, REG_IMAGE_HEIGHT, 16'd0, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h55, 1'b0, 1'b0, NO_WORD},
    // stream ends on a packet header
    '{ROW_REG, REG_IMAGE_HEIGHT, 16'd2, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h80, 1'b1, 1'b1, '{32'h0, 8'd0, 1'b0, FAULT_TRUNCATED}},
    // oversize pixel setting taken as four; stream ends on a full run pixel
    '{ROW_REG, REG_PIXEL_BYTES, 16'd7, '0, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h81, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h10, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, '0, '0, 8'h20, 1'b0, 1'b0, NO_WORD}
  };

  // tail of the last directed run pixel, kept apart to close that frame
  localparam logic [7:0] TAIL_BYTES [2] = '{8'h30, 8'h40};
  localparam pixel_word_t TAIL_WORD = '{32'h4030_2010, 8'd2, 1'b0, FAULT_TRUNCATED};

  logic clk;
  logic rst;

  tga_cfg_if   cfg_bus ();
  tga_byte_if  byte_bus ();
  tga_pixel_if pixel_bus ();

  tga_rle_pixel_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_bus),
    .data_in   (byte_bus),
    .pixel_out (pixel_bus)
  );

  // Decoder mirror: frame registers and per-frame progress
  logic        cfg_rle;
  logic [2:0]  cfg_pix_bytes;
  logic [15:0] cfg_width;
  logic [15:0] cfg_height;
  logic        hdr_due;
  logic        in_run;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_pos;
  logic [31:0] pix_acc;
  logic [31:0] px_todo;
  logic        frame_over;

  pixel_word_t pending_pixels [$];

  int src_idle_pct;
  int sink_stall_pct;
  int errors;
  int bytes_used;
  int words_checked;
  int reg_writes;
  int frames;
  int seen_done;
  int seen_clipped;
  int seen_truncated;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Start a new frame from the current register values
  function automatic void reload_frame();
    hdr_due    = 1'b1;
    in_run     = 1'b0;
    pkt_left   = '0;
    byte_pos   = '0;
    pix_acc    = '0;
    px_todo    = 32'(cfg_width) * 32'(cfg_height);
    frame_over = (px_todo == 0);
  endfunction

  // Advance the mirror by one byte; returns 1 when a pixel word is due
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output pixel_word_t res);
    logic [2:0]  pb;
    logic [31:0] cnt;
    logic [1:0]  flt;
    res = '0;
    if (frame_over) return 1'b0;
    pb = (cfg_pix_bytes == 0) ? 3'd1 : (cfg_pix_bytes > 4) ? 3'd4 : cfg_pix_bytes;

    // packet header
    if (cfg_rle && hdr_due) begin
      if (b < MAX_PACKET) begin
        in_run   = 1'b0;
        pkt_left = b + 8'd1;
      end else begin
        in_run   = 1'b1;
        pkt_left = b - 8'(MAX_PACKET - 1);
      end
      hdr_due  = 1'b0;
      byte_pos = '0;
      pix_acc  = '0;
      if (last) begin
        frame_over = 1'b1;
        res.fault  = FAULT_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end

    // pixel byte, little-endian
    pix_acc |= 32'(b) << (8 * byte_pos);
    if (byte_pos + 1 < pb) begin
      byte_pos = byte_pos + 2'd1;
      if (last) begin
        frame_over = 1'b1;
        res.fault  = FAULT_TRUNCATED;
        return 1'b1;
      end
      return 1'b0;
    end

    // pixel complete
    res.pixel_value = pix_acc;
    byte_pos = '0;
    pix_acc  = '0;
    if (cfg_rle && in_run) begin
      cnt      = 32'(pkt_left);
      pkt_left = '0;
    end else begin
      cnt = 1;
      if (cfg_rle && pkt_left > 0) pkt_left = pkt_left - 8'd1;
    end
    if (cfg_rle && pkt_left == 0) hdr_due = 1'b1;

    flt = FAULT_OK;
    if (cnt > px_todo) begin
      cnt = px_todo;
      flt = FAULT_CLIPPED;
    end
    px_todo = px_todo - cnt;
    res.repeat_count = cnt[7:0];

    if (px_todo == 0) begin
      if (cfg_rle && !hdr_due && pkt_left > 0) flt = FAULT_CLIPPED;
      frame_over     = 1'b1;
      res.image_done = 1'b1;
      res.fault      = flt;
    end else if (last) begin
      frame_over = 1'b1;
      res.fault  = FAULT_TRUNCATED;
    end else begin
      res.fault = flt;
    end
    return 1'b1;
  endfunction

  // Hold off the source until every pending word has come out
  task automatic wait_drained();
    byte_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_RLE_MODE:     cfg_rle       = val[0];
      REG_PIXEL_BYTES:  cfg_pix_bytes = val[2:0];
      REG_IMAGE_WIDTH:  cfg_width     = val;
      REG_IMAGE_HEIGHT: cfg_height    = val;
      default: ;
    endcase
    reload_frame();
    reg_writes++;
  endtask

  // Offer one byte word; queue the predicted (or the given) pixel word
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit typed, input pixel_word_t want);
    int          gap;
    bit          got;
    pixel_word_t res;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.data_byte  <= b;
    byte_bus.stream_end <= last;
    do @(posedge clk); while (!byte_bus.ready);
    if (!frame_over) bytes_used++;
    got = decode_byte(b, last, res);
    if (typed) pending_pixels.push_back(want);
    else if (got) pending_pixels.push_back(res);
  endtask

  // One random frame: new settings, mostly well-formed packets, then an ending
  task automatic run_frame();
    logic [8:0]  words [$];
    logic        new_rle;
    logic [2:0]  new_pb;
    logic [15:0] new_w;
    logic [15:0] new_h;
    longint      left;
    int          pb;
    int          n;
    int          cut;
    int          ending;
    bit          wrote;

    new_rle = ($urandom_range(9) < 7);
    new_pb  = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
    case ($urandom_range(19))
      0: begin
        if ($urandom_range(1)) begin
          new_w = '0;
          new_h = 16'($urandom_range(0, 3));
        end else begin
          new_w = 16'($urandom_range(0, 3));
          new_h = '0;
        end
      end
      1: begin
        new_w = 16'hFFFF;
        new_h = $urandom_range(1) ? 16'd1 : 16'hFFFF;
      end
      2: begin
        new_w = 16'($urandom_range(1, 65535));
        new_h = 16'hFFFF;
      end
      default: begin
        new_w = 16'($urandom_range(1, 6));
        new_h = 16'($urandom_range(1, 4));
      end
    endcase

    // write what changed, plus some unchanged registers
    wrote = 1'b0;
    if (new_rle != cfg_rle || $urandom_range(2) == 0) begin
      write_reg(REG_RLE_MODE, 16'(new_rle));
      wrote = 1'b1;
    end
    if (new_pb != cfg_pix_bytes || $urandom_range(2) == 0) begin
      write_reg(REG_PIXEL_BYTES, 16'(new_pb));
      wrote = 1'b1;
    end
    if (new_w != cfg_width || $urandom_range(2) == 0) begin
      write_reg(REG_IMAGE_WIDTH, new_w);
      wrote = 1'b1;
    end
    if (new_h != cfg_height || $urandom_range(2) == 0) begin
      write_reg(REG_IMAGE_HEIGHT, new_h);
      wrote = 1'b1;
    end
    if (!wrote) write_reg(REG_IMAGE_WIDTH, new_w);

    // build the byte stream, capped for very large images
    pb   = (new_pb == 0) ? 1 : (new_pb > 4) ? 4 : int'(new_pb);
    left = longint'(new_w) * longint'(new_h);
    while (left > 0 && words.size() < 96) begin
      if (new_rle) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        if ($urandom_range(1)) begin
          words.push_back({1'b0, 8'(n + 127)});
          repeat (pb) words.push_back({1'b0, 8'($urandom_range(255))});
        end else begin
          if (n > left + 2) n = int'(left + 2);
          words.push_back({1'b0, 8'(n - 1)});
          repeat (n * pb) words.push_back({1'b0, 8'($urandom_range(255))});
        end
        left -= n;
      end else begin
        repeat (pb) words.push_back({1'b0, 8'($urandom_range(255))});
        left--;
      end
    end

    // ending: early stream end, abandoned frame, or normal finish
    ending = $urandom_range(9);
    if (words.size() > 0) begin
      if (ending < 3) begin
        cut = $urandom_range(words.size() - 1);
        while (words.size() > cut + 1) void'(words.pop_back());
        words[cut][8] = 1'b1;
      end else if (ending == 3) begin
        cut = $urandom_range(words.size() - 1);
        while (words.size() > cut + 1) void'(words.pop_back());
      end else if (left > 0 || $urandom_range(1)) begin
        words[words.size() - 1][8] = 1'b1;
      end
    end
    // trailing noise
    repeat ($urandom_range(2)) words.push_back(9'($urandom_range(511)));

    foreach (words[i]) begin
      if ($urandom_range(63) == 0) wait_drained();
      send_byte(words[i][7:0], words[i][8], 1'b0, NO_WORD);
    end
    frames++;
  endtask

  // Pixel word checker and sink stall driver
  initial begin
    pixel_word_t want;
    pixel_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pixel_bus.valid && pixel_bus.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel word with none expected: value %h count %0d done %0d fault %0d",
                 pixel_bus.pixel_value, pixel_bus.repeat_count,
                 pixel_bus.image_done, pixel_bus.fault);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          words_checked++;
          if (want.image_done) seen_done++;
          if (want.fault == FAULT_CLIPPED) seen_clipped++;
          if (want.fault == FAULT_TRUNCATED) seen_truncated++;
          if (pixel_bus.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %h, got %h", want.pixel_value,
                   pixel_bus.pixel_value);
            errors++;
          end
          if (pixel_bus.repeat_count !== want.repeat_count) begin
            $error("repeat_count: expected %0d, got %0d", want.repeat_count,
                   pixel_bus.repeat_count);
            errors++;
          end
          if (pixel_bus.image_done !== want.image_done) begin
            $error("image_done: expected %0d, got %0d", want.image_done,
                   pixel_bus.image_done);
            errors++;
          end
          if (pixel_bus.fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, pixel_bus.fault);
            errors++;
          end
        end
      end
      pixel_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Stimulus
  initial begin
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    errors         = 0;
    bytes_used     = 0;
    words_checked  = 0;
    reg_writes     = 0;
    frames         = 0;
    seen_done      = 0;
    seen_clipped   = 0;
    seen_truncated = 0;

    rst                 <= 1'b1;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= REG_RLE_MODE;
    cfg_bus.data        <= '0;
    byte_bus.valid      <= 1'b0;
    byte_bus.data_byte  <= '0;
    byte_bus.stream_end <= 1'b0;

    // reset values of the frame registers
    cfg_rle       = 1'b1;
    cfg_pix_bytes = 3'd3;
    cfg_width     = 16'd1;
    cfg_height    = 16'd1;
    reload_frame();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed sequence
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_REG) write_reg(PLAN[r].idx, PLAN[r].val);
      else send_byte(PLAN[r].b, PLAN[r].last, PLAN[r].typed, PLAN[r].want);
    end
    send_byte(TAIL_BYTES[0], 1'b0, 1'b0, NO_WORD);
    send_byte(TAIL_BYTES[1], 1'b1, 1'b1, TAIL_WORD);

    // random frames under each idle/stall mix
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      src_idle_pct   = SRC_IDLE_PCT[ph];
      sink_stall_pct = SINK_STALL_PCT[ph];
      while (bytes_used < (ph + 1) * PHASE_BYTES + 24) run_frame();
    end

    wait_drained();
    repeat (6) @(posedge clk);

    $display("Run: %0d decoded bytes over %0d random frames, %0d register writes, %0d words",
             bytes_used, frames, reg_writes, words_checked);
    $display("Run: %0d images completed, %0d clipped packets, %0d early stream ends",
             seen_done, seen_clipped, seen_truncated);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
